>>> rtl/core/page_replacement_engine_defines.svh
// Assertion macros used by the page replacement engine sequencer (pre_ctrl).
`ifndef PAGE_REPLACEMENT_ENGINE_DEFINES_SVH
`define PAGE_REPLACEMENT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PRE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pre_pkg.sv
// Shared types and constants of the page replacement engine.
package pre_pkg;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_CLOCK = 2'd1;
    localparam logic [1:0] POL_LRU   = 2'd2;

    localparam logic [1:0] CFG_POLICY  = 2'd0;
    localparam logic [1:0] CFG_PREPAGE = 2'd1;
    localparam logic [1:0] CFG_FRAMES  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [15:0] page;
        logic        refb;
        logic [31:0] last;
    } entry_t;

    typedef struct packed {
        logic [1:0] policy;
        logic       prepage;
        logic [9:0] frames;
    } cfg_t;

endpackage

>>> rtl/core/pre_frame_mem.sv
// Frame table memory: one write port, one registered read port with write forwarding.
module pre_frame_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  pre_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output pre_pkg::entry_t rdata
);
    import pre_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // A read of the entry being written returns the new contents.
        if (re)
        begin
            rdata_reg <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pre_ctrl.sv
// Sequencer: table clearing, lookup scan, replacement and result register.
`include "page_replacement_engine_defines.svh"

module pre_ctrl #(
    parameter int MAX_FRAMES = 512,
    parameter int FW         = 9,
    parameter int NW         = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pre_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            func,
    input  logic [8:0]      frame_sel,
    input  logic [15:0]     page_id,
    input  logic            page_present,
    input  logic [15:0]     next_page_id,
    input  logic            has_next,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            hit,
    output logic [8:0]      frame_out,
    output logic            prepaged,
    output logic [31:0]     fault_total,
    output logic            mem_we,
    output logic [FW-1:0]   mem_waddr,
    output pre_pkg::entry_t mem_wdata,
    output logic            mem_re,
    output logic [FW-1:0]   mem_raddr,
    input  pre_pkg::entry_t mem_rdata
);
    import pre_pkg::*;

    localparam logic [31:0] MAX32 = MAX_FRAMES;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_RD, S_WR, S_SWEEP, S_DONE
    } state_t;

    typedef enum logic [1:0] {OP_LOAD, OP_HIT, OP_MAIN, OP_PRE} op_t;

    state_t        st_reg, st_next;
    op_t           op_reg, op_next;
    logic [FW-1:0] clr_reg, clr_next;
    logic          func_reg, func_next;
    logic [8:0]    sel_reg, sel_next;
    logic [15:0]   page_reg, page_next;
    logic          present_reg, present_next;
    logic [15:0]   nxt_reg, nxt_next;
    logic          has_next_reg, has_next_next;
    logic [NW-1:0] n_reg, n_next;
    logic [FW-1:0] hand_reg, hand_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic [31:0]   fault_reg, fault_next;
    logic [NW-1:0] issue_reg, issue_next;
    logic          rv_reg, rv_next;
    logic [FW-1:0] ridx_reg, ridx_next;
    logic          hit_found_reg, hit_found_next;
    logic [FW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]   min_reg, min_next;
    logic [FW-1:0] victim_reg, victim_next;
    logic          nf_reg, nf_next;
    logic [FW-1:0] nidx_reg, nidx_next;
    logic          nmulti_reg, nmulti_next;
    logic [FW-1:0] tgt_reg, tgt_next;
    logic          pre_reg, pre_next;
    logic [FW-1:0] fout_reg, fout_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_hit_reg, out_hit_next;
    logic [8:0]    out_frame_reg, out_frame_next;
    logic          out_pre_reg, out_pre_next;
    logic [31:0]   out_fault_reg, out_fault_next;

    logic [NW-1:0] n_calc;
    logic [31:0]   fiu;
    logic          want_pre;
    logic          resident;
    entry_t        wr_ent;
    entry_t        clr_ent;

    function automatic logic [FW-1:0] adv(input logic [FW-1:0] f, input logic [NW-1:0] n);
        logic [NW:0] s;
        s = (NW+1)'(f) + (NW+1)'(1);
        return (s >= (NW+1)'(n)) ? '0 : FW'(s);
    endfunction

    always_comb
    begin
        fiu = 32'(cfg.frames);
        if (fiu == 32'd0)
        begin
            n_calc = NW'(1);
        end
        else if (fiu > MAX32)
        begin
            n_calc = NW'(MAX32);
        end
        else
        begin
            n_calc = NW'(fiu);
        end
    end

    assign want_pre = cfg.prepage && has_next_reg && (n_reg > NW'(1));
    // The next page counts as resident if the new page is that page, or
    // another frame than the one just written already holds it.
    assign resident = (page_reg == nxt_reg) ||
                      (nf_reg && (nmulti_reg || nidx_reg != tgt_reg));

    always_comb
    begin
        clr_ent       = '0;
        clr_ent.refb  = 1'b1;
        wr_ent        = mem_rdata;
        case (op_reg)
            OP_LOAD:
            begin
                wr_ent.valid = present_reg;
                wr_ent.page  = present_reg ? page_reg : 16'd0;
            end
            OP_HIT:
            begin
                wr_ent.refb = 1'b1;
                wr_ent.last = stamp_reg;
            end
            OP_MAIN, OP_PRE:
            begin
                wr_ent.valid = 1'b1;
                wr_ent.page  = (op_reg == OP_MAIN) ? page_reg : nxt_reg;
                if (cfg.policy == POL_CLOCK)
                begin
                    wr_ent.refb = 1'b1;
                end
                if (cfg.policy == POL_LRU)
                begin
                    wr_ent.last = stamp_reg;
                end
            end
            default:
            begin
                wr_ent = mem_rdata;
            end
        endcase
    end

    always_comb
    begin
        st_next        = st_reg;
        op_next        = op_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        sel_next       = sel_reg;
        page_next      = page_reg;
        present_next   = present_reg;
        nxt_next       = nxt_reg;
        has_next_next  = has_next_reg;
        n_next         = n_reg;
        hand_next      = hand_reg;
        stamp_next     = stamp_reg;
        fault_next     = fault_reg;
        issue_next     = issue_reg;
        ridx_next      = ridx_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        min_next       = min_reg;
        victim_next    = victim_reg;
        nf_next        = nf_reg;
        nidx_next      = nidx_reg;
        nmulti_next    = nmulti_reg;
        tgt_next       = tgt_reg;
        pre_next       = pre_reg;
        fout_next      = fout_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_frame_next = out_frame_reg;
        out_pre_next   = out_pre_reg;
        out_fault_next = out_fault_reg;
        mem_we         = 1'b0;
        mem_waddr      = tgt_reg;
        mem_wdata      = wr_ent;
        mem_re         = 1'b0;
        mem_raddr      = tgt_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (st_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = clr_ent;
                clr_next  = clr_reg + FW'(1);
                if (clr_reg == FW'(MAX_FRAMES - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next      = func;
                    sel_next       = frame_sel;
                    page_next      = page_id;
                    present_next   = page_present;
                    nxt_next       = next_page_id;
                    has_next_next  = has_next;
                    n_next         = n_calc;
                    hit_found_next = 1'b0;
                    nf_next        = 1'b0;
                    nmulti_next    = 1'b0;
                    pre_next       = 1'b0;
                    issue_next     = '0;
                    // Only an access wraps the hand; a load leaves it alone.
                    if (func && NW'(hand_reg) >= n_calc)
                    begin
                        hand_next = '0;
                    end
                    if (!func)
                    begin
                        tgt_next = FW'(frame_sel);
                        op_next  = OP_LOAD;
                        st_next  = (32'(frame_sel) < MAX32) ? S_RD : S_DONE;
                    end
                    else
                    begin
                        st_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue_reg < n_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = issue_reg[FW-1:0];
                    issue_next = issue_reg + NW'(1);
                end
                if (rv_reg)
                begin
                    if (!hit_found_reg && mem_rdata.valid && mem_rdata.page == page_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = ridx_reg;
                    end
                    if (ridx_reg == '0 || mem_rdata.last < min_reg)
                    begin
                        min_next    = mem_rdata.last;
                        victim_next = ridx_reg;
                    end
                    if (mem_rdata.valid && mem_rdata.page == nxt_reg)
                    begin
                        if (!nf_reg)
                        begin
                            nf_next   = 1'b1;
                            nidx_next = ridx_reg;
                        end
                        else
                        begin
                            nmulti_next = 1'b1;
                        end
                    end
                end
                if (issue_reg == n_reg && !rv_reg)
                begin
                    st_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (hit_found_reg)
                begin
                    tgt_next  = hit_idx_reg;
                    fout_next = hit_idx_reg;
                    op_next   = OP_HIT;
                    st_next   = S_RD;
                end
                else
                begin
                    fault_next = fault_reg + 32'd1;
                    op_next    = OP_MAIN;
                    case (cfg.policy)
                        POL_FIFO:
                        begin
                            tgt_next = hand_reg;
                            st_next  = S_RD;
                        end
                        POL_CLOCK:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = hand_reg;
                            st_next   = S_SWEEP;
                        end
                        POL_LRU:
                        begin
                            tgt_next = victim_reg;
                            st_next  = S_RD;
                        end
                        default:
                        begin
                            fout_next = '0;
                            st_next   = S_DONE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                mem_re  = 1'b1;
                st_next = S_WR;
            end
            S_WR:
            begin
                mem_we = 1'b1;
                case (op_reg)
                    OP_MAIN:
                    begin
                        fout_next = tgt_reg;
                        if (cfg.policy != POL_LRU)
                        begin
                            hand_next = adv(tgt_reg, n_reg);
                        end
                        if (want_pre && !resident)
                        begin
                            tgt_next = adv(tgt_reg, n_reg);
                            op_next  = OP_PRE;
                            st_next  = S_RD;
                        end
                        else
                        begin
                            st_next = S_DONE;
                        end
                    end
                    OP_PRE:
                    begin
                        pre_next = 1'b1;
                        if (cfg.policy != POL_LRU)
                        begin
                            hand_next = adv(tgt_reg, n_reg);
                        end
                        st_next = S_DONE;
                    end
                    default:
                    begin
                        st_next = S_DONE;
                    end
                endcase
            end
            S_SWEEP:
            begin
                // Referenced valid frames lose their bit and are passed over.
                if (mem_rdata.refb && mem_rdata.valid)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = hand_reg;
                    mem_wdata      = mem_rdata;
                    mem_wdata.refb = 1'b0;
                    hand_next      = adv(hand_reg, n_reg);
                    mem_re         = 1'b1;
                    mem_raddr      = adv(hand_reg, n_reg);
                end
                else
                begin
                    tgt_next = hand_reg;
                    st_next  = S_WR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = func_reg && hit_found_reg;
                    out_frame_next = func_reg ? 9'(fout_reg) : sel_reg;
                    out_pre_next   = pre_reg;
                    out_fault_next = fault_reg;
                    if (func_reg)
                    begin
                        stamp_next = stamp_reg + 32'd1;
                    end
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        rv_next   = mem_re && (st_reg == S_SCAN);
        ridx_next = mem_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLEAR;
            clr_reg       <= '0;
            hand_reg      <= '0;
            stamp_reg     <= 32'd1;
            fault_reg     <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_frame_reg <= '0;
            out_pre_reg   <= 1'b0;
            out_fault_reg <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            hand_reg      <= hand_next;
            stamp_reg     <= stamp_next;
            fault_reg     <= fault_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_frame_reg <= out_frame_next;
            out_pre_reg   <= out_pre_next;
            out_fault_reg <= out_fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        func_reg      <= func_next;
        sel_reg       <= sel_next;
        page_reg      <= page_next;
        present_reg   <= present_next;
        nxt_reg       <= nxt_next;
        has_next_reg  <= has_next_next;
        n_reg         <= n_next;
        issue_reg     <= issue_next;
        ridx_reg      <= ridx_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        min_reg       <= min_next;
        victim_reg    <= victim_next;
        nf_reg        <= nf_next;
        nidx_reg      <= nidx_next;
        nmulti_reg    <= nmulti_next;
        tgt_reg       <= tgt_next;
        pre_reg       <= pre_next;
        fout_reg      <= fout_next;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign frame_out   = out_frame_reg;
    assign prepaged    = out_pre_reg;
    assign fault_total = out_fault_reg;

    `PRE_ASSERT_IMPL(a_fault_step, fault_reg != $past(fault_reg), $past(st_reg == S_DECIDE) && fault_reg == $past(fault_reg) + 32'd1, "fault count moved outside a miss")
    `PRE_ASSERT_IMPL(a_result_source, $rose(out_valid_reg), $past(st_reg == S_DONE), "result appeared without a finished item")
    `PRE_ASSERT_IMPL(a_hand_range, st_reg == S_DONE && func_reg, NW'(hand_reg) < n_reg, "clock hand outside the active frames")
    `PRE_ASSERT_NEXT(a_prepage_done, st_reg == S_WR && op_reg == OP_PRE, st_reg == S_DONE && pre_reg, "pre-paging write not reported")

endmodule

>>> rtl/core/page_replacement_engine.sv
// Page replacement engine top level: configuration registers, sequencer and frame table.
// After reset the frame table is cleared one frame per cycle, during which no item is
// taken. An access item reads the active frames n one per cycle through the single
// table read port; on a miss under the clock policy the hand sweep then passes over
// each referenced frame, up to n of them. The result is held in an output register,
// so the next item is accepted while a result still waits to be taken.
module page_replacement_engine #(
    parameter int MAX_FRAMES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [8:0]  frame_sel,
    input  logic [15:0] page_id,
    input  logic        page_present,
    input  logic [15:0] next_page_id,
    input  logic        has_next,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [8:0]  frame_out,
    output logic        prepaged,
    output logic [31:0] fault_total
);
    import pre_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int NW = $clog2(MAX_FRAMES + 1);

    cfg_t          cfg_reg;
    logic          mem_we;
    logic [FW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [FW-1:0] mem_raddr;
    entry_t        mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy  <= POL_FIFO;
            cfg_reg.prepage <= 1'b0;
            cfg_reg.frames  <= 10'd512;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLICY:  cfg_reg.policy  <= cfg_data[1:0];
                CFG_PREPAGE: cfg_reg.prepage <= cfg_data[0];
                CFG_FRAMES:  cfg_reg.frames  <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    pre_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .FW         (FW),
        .NW         (NW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .frame_sel    (frame_sel),
        .page_id      (page_id),
        .page_present (page_present),
        .next_page_id (next_page_id),
        .has_next     (has_next),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .frame_out    (frame_out),
        .prepaged     (prepaged),
        .fault_total  (fault_total),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    pre_frame_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (FW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
